FILE: sv/lprt_pkg.sv
// Shared types, codes and helper functions of the longest-prefix route table.
package lprt_pkg;

  localparam int PORT_COUNT = 16;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_LOOKUP = 1'b1;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_FULL     = 2'd1;
  localparam logic [1:0] ST_DUP      = 2'd2;
  localparam logic [1:0] ST_BAD_PORT = 2'd3;

  typedef struct packed {
    logic        opcode;
    logic [31:0] address;
    logic [31:0] prefix_mask;
    logic [3:0]  hop_port;
  } lprt_in_t;

  typedef struct packed {
    logic       hit;
    logic [3:0] next_hop;
    logic [5:0] match_length;
    logic [1:0] status;
  } lprt_out_t;

  // Search token that walks down the row of entry cells.
  typedef struct packed {
    logic        active;
    logic        opcode;
    logic [31:0] address;
    logic [31:0] mask;
    logic [5:0]  length;
    logic [3:0]  port;
    logic        port_bad;
    logic        dup;
    logic        placed;
    logic        hit;
    logic [5:0]  hit_len;
    logic [3:0]  hit_port;
  } lprt_tok_t;

  function automatic logic [5:0] ones_in(logic [31:0] v);
    logic [3:0] byte_cnt [4];
    for (int b = 0; b < 4; b++) begin
      byte_cnt[b] = 4'd0;
      for (int j = 0; j < 8; j++) begin
        byte_cnt[b] = byte_cnt[b] + {3'd0, v[b*8+j]};
      end
    end
    return ({2'd0, byte_cnt[0]} + {2'd0, byte_cnt[1]})
         + ({2'd0, byte_cnt[2]} + {2'd0, byte_cnt[3]});
  endfunction

endpackage

FILE: sv/lprt_chan_if.sv
// Valid/ready channel carrying one payload beat.
interface lprt_chan_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

FILE: sv/longest_prefix_route_table.sv
// Top level of the longest-prefix route table built as a row of entry cells.
// Each insert or lookup beat becomes a token that walks the row of TABLE_DEPTH
// entry cells one cell per cycle unless the row is stalled; each cell holds one
// route, compares it with the token and, for an insert, the first free cell
// takes the route. One item is in the row at a time; it passes the entry
// register, TABLE_DEPTH cells and the output register on its way from
// acceptance to its result beat. A result waiting in the output register stalls
// the row only when the next result is ready to leave it. Inserts report ok,
// duplicate, table full, or an unknown port; lookups report the port and mask
// length of the longest matching route, the earliest one winning ties.
module longest_prefix_route_table #(
  parameter int TABLE_DEPTH = 16
) (
  input logic clk,
  input logic rst_n,
  lprt_chan_if.sink   in_chan,
  lprt_chan_if.source out_chan
);
  import lprt_pkg::*;

  lprt_tok_t tok0_r;
  lprt_tok_t chain [TABLE_DEPTH+1];
  lprt_tok_t last;
  logic      busy_r;
  logic      out_valid_r;
  lprt_out_t out_data_r;
  lprt_out_t result;
  logic      adv;
  logic      accept;

  assign in_chan.ready = !busy_r;
  assign accept        = in_chan.valid && !busy_r;
  assign last          = chain[TABLE_DEPTH];
  assign adv           = !(last.active && out_valid_r && !out_chan.ready);
  assign chain[0]      = tok0_r;

  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    lprt_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .adv     (adv),
      .tok_in  (chain[i]),
      .tok_out (chain[i+1])
    );
  end

  always_comb begin
    result = '0;
    if (last.opcode == OP_INSERT) begin
      priority if (last.port_bad) begin
        result.status = ST_BAD_PORT;
      end else if (last.dup) begin
        result.status = ST_DUP;
      end else if (last.placed) begin
        result.status = ST_OK;
      end else begin
        result.status = ST_FULL;
      end
    end else begin
      result.hit          = last.hit;
      result.next_hop     = last.hit_port;
      result.match_length = last.hit_len;
      result.status       = ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok0_r      <= '0;
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        tok0_r.active   <= 1'b1;
        tok0_r.opcode   <= in_chan.data.opcode;
        tok0_r.address  <= in_chan.data.address;
        tok0_r.mask     <= in_chan.data.prefix_mask;
        tok0_r.length   <= ones_in(in_chan.data.prefix_mask);
        tok0_r.port     <= in_chan.data.hop_port;
        tok0_r.port_bad <= int'(in_chan.data.hop_port) >= PORT_COUNT;
        tok0_r.dup      <= 1'b0;
        tok0_r.placed   <= 1'b0;
        tok0_r.hit      <= 1'b0;
        tok0_r.hit_len  <= 6'd0;
        tok0_r.hit_port <= 4'd0;
      end else if (adv) begin
        tok0_r.active <= 1'b0;
      end

      if (accept) begin
        busy_r <= 1'b1;
      end else if (adv && last.active) begin
        busy_r <= 1'b0;
      end

      if (adv && last.active) begin
        out_valid_r <= 1'b1;
        out_data_r  <= result;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_chan.valid = out_valid_r;
  assign out_chan.data  = out_data_r;

endmodule

FILE: sv/lprt_cell.sv
// One route entry cell: holds a route and processes the passing search token.
module lprt_cell (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              adv,
  input  lprt_pkg::lprt_tok_t tok_in,
  output lprt_pkg::lprt_tok_t tok_out
);
  import lprt_pkg::*;

  logic        ent_valid_r;
  logic [31:0] ent_prefix_r;
  logic [31:0] ent_mask_r;
  logic [5:0]  ent_len_r;
  logic [3:0]  ent_port_r;
  lprt_tok_t   tok_r;
  lprt_tok_t   tok_nxt;
  logic        wr;

  always_comb begin
    tok_nxt = tok_in;
    wr      = 1'b0;
    if (tok_in.active) begin
      if (tok_in.opcode == OP_INSERT) begin
        // Entries fill from the front, so every stored route is checked for a
        // duplicate before the token reaches the first free cell.
        if (!tok_in.port_bad && !tok_in.dup && !tok_in.placed) begin
          if (ent_valid_r) begin
            if (ent_prefix_r == tok_in.address && ent_mask_r == tok_in.mask) begin
              tok_nxt.dup = 1'b1;
            end
          end else begin
            wr             = 1'b1;
            tok_nxt.placed = 1'b1;
          end
        end
      end else begin
        if (ent_valid_r && ((tok_in.address & ent_mask_r) == ent_prefix_r) &&
            (!tok_in.hit || ent_len_r > tok_in.hit_len)) begin
          tok_nxt.hit      = 1'b1;
          tok_nxt.hit_len  = ent_len_r;
          tok_nxt.hit_port = ent_port_r;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ent_valid_r <= 1'b0;
      tok_r       <= '0;
    end else if (adv) begin
      tok_r <= tok_nxt;
      if (wr) begin
        ent_valid_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv && wr) begin
      ent_prefix_r <= tok_in.address;
      ent_mask_r   <= tok_in.mask;
      ent_len_r    <= tok_in.length;
      ent_port_r   <= tok_in.port;
    end
  end

  assign tok_out = tok_r;

endmodule

FILE: tb/longest_prefix_route_table_tb.sv
// Testbench for the longest-prefix route table: directed and random inserts and lookups.
`timescale 1ns / 1ps

module longest_prefix_route_table_tb;
  import lprt_pkg::*;

  localparam int TABLE_DEPTH = 16;
  localparam int RANDOM_ITEMS = 1280;

  logic clk = 1'b0;
  logic rst_n;

  lprt_chan_if #(.payload_t(lprt_in_t))  in_chan ();
  lprt_chan_if #(.payload_t(lprt_out_t)) out_chan ();

  longest_prefix_route_table #(.TABLE_DEPTH(TABLE_DEPTH)) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Our own copy of the route table, updated as each request beat is accepted.
  logic [31:0] tbl_prefix [TABLE_DEPTH];
  logic [31:0] tbl_mask [TABLE_DEPTH];
  logic [5:0]  tbl_len [TABLE_DEPTH];
  logic [3:0]  tbl_port [TABLE_DEPTH];
  int          tbl_count = 0;

  lprt_in_t  route_requests [$];
  lprt_out_t route_replies_due [$];
  int        drain_marks [$];

  // Both counters are written with nonblocking assignments, so the other block reads a
  // stable value at each edge.
  int items_sent = 0;
  int results_got = 0;
  int fail_count = 0;
  int gap_left = 0;
  int burst_left = 0;
  int rdy_cycle = 0;

  function automatic lprt_out_t predict_route_reply(lprt_in_t req);
    lprt_out_t reply;
    logic      present;
    reply = '0;
    reply.status = ST_OK;
    present = 1'b0;
    if (req.opcode == OP_INSERT) begin
      if (int'(req.hop_port) >= PORT_COUNT) begin
        reply.status = ST_BAD_PORT;
      end else begin
        for (int i = 0; i < tbl_count; i++) begin
          if (tbl_prefix[i] == req.address && tbl_mask[i] == req.prefix_mask) begin
            present = 1'b1;
          end
        end
        if (present) begin
          reply.status = ST_DUP;
        end else if (tbl_count >= TABLE_DEPTH) begin
          reply.status = ST_FULL;
        end else begin
          tbl_prefix[tbl_count] = req.address;
          tbl_mask[tbl_count] = req.prefix_mask;
          tbl_len[tbl_count] = 6'($countones(req.prefix_mask));
          tbl_port[tbl_count] = req.hop_port;
          tbl_count++;
        end
      end
    end else begin
      // A strictly longer mask replaces the current winner, so ties keep the earliest entry.
      for (int i = 0; i < tbl_count; i++) begin
        if ((req.address & tbl_mask[i]) == tbl_prefix[i] &&
            (!reply.hit || tbl_len[i] > reply.match_length)) begin
          reply.hit = 1'b1;
          reply.match_length = tbl_len[i];
          reply.next_hop = tbl_port[i];
        end
      end
    end
    return reply;
  endfunction

  function automatic lprt_in_t make_request(logic op, logic [31:0] addr, logic [31:0] mask,
                                            logic [3:0] port);
    lprt_in_t req;
    req.opcode = op;
    req.address = addr;
    req.prefix_mask = mask;
    req.hop_port = port;
    return req;
  endfunction

  task automatic add_request(logic op, logic [31:0] addr, logic [31:0] mask,
                             logic [3:0] port);
    route_requests = {route_requests, make_request(op, addr, mask, port)};
  endtask

  function automatic logic [31:0] mask_of_length(int bits);
    return (bits == 0) ? 32'h0 : ~32'h0 << (32 - bits);
  endfunction

  task automatic report_field(string field, int want, int got);
    fail_count++;
    $display("%0t: %s mismatch, expected %0d, actual %0d", $realtime, field, want, got);
  endtask

  // Sender: bursts of request beats separated by random gaps, with hold-offs until the
  // table has answered everything sent so far.
  always @(posedge clk) begin
    int accepted;
    accepted = items_sent;
    if (!rst_n) begin
      in_chan.valid <= 1'b0;
      in_chan.data <= '0;
    end else begin
      if (in_chan.valid && in_chan.ready) begin
        route_replies_due = {route_replies_due, predict_route_reply(in_chan.data)};
        accepted++;
      end
      items_sent <= accepted;
      if (drain_marks.size() != 0 && accepted == drain_marks[0] && results_got == accepted) begin
        drain_marks.pop_front();
      end
      if (!in_chan.valid || in_chan.ready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_chan.valid <= 1'b0;
        end else if (route_requests.size() == 0 ||
                     (drain_marks.size() != 0 && accepted == drain_marks[0])) begin
          in_chan.valid <= 1'b0;
        end else begin
          in_chan.data <= route_requests.pop_front();
          in_chan.valid <= 1'b1;
          if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
          end
          burst_left--;
          if (burst_left == 0) begin
            gap_left = ($urandom_range(0, 3) == 0) ? $urandom_range(8, 30) : $urandom_range(1, 4);
          end
        end
      end
    end
  end

  // Receiver: cycles through always ready, coin-flip ready and long periodic stalls.
  always @(posedge clk) begin
    lprt_out_t want;
    if (!rst_n) begin
      out_chan.ready <= 1'b0;
    end else begin
      if (out_chan.valid && out_chan.ready) begin
        results_got <= results_got + 1;
        if (route_replies_due.size() == 0) begin
          fail_count++;
          $display("%0t: result beat with nothing expected, actual %p", $realtime, out_chan.data);
        end else begin
          want = route_replies_due.pop_front();
          if (out_chan.data.hit !== want.hit)
            report_field("hit", int'(want.hit), int'(out_chan.data.hit));
          if (out_chan.data.next_hop !== want.next_hop)
            report_field("next_hop", int'(want.next_hop), int'(out_chan.data.next_hop));
          if (out_chan.data.match_length !== want.match_length)
            report_field("match_length", int'(want.match_length),
                         int'(out_chan.data.match_length));
          if (out_chan.data.status !== want.status)
            report_field("status", int'(want.status), int'(out_chan.data.status));
        end
      end
      rdy_cycle++;
      unique case ((rdy_cycle / 97) % 3)
        0: begin
          out_chan.ready <= 1'b1;
        end
        1: begin
          out_chan.ready <= 1'($urandom_range(0, 1));
        end
        default: begin
          out_chan.ready <= (rdy_cycle % 16) >= 10;
        end
      endcase
    end
  end

  initial begin
    logic [31:0] issued_prefix [$];
    logic [31:0] issued_mask [$];
    logic [31:0] addr;
    logic [31:0] mask;
    int          pick;
    int          kind;
    int          k;

    rst_n = 1'b0;

    // Lookups on the empty table miss.
    add_request(OP_LOOKUP, 32'h0000_0000, 32'hFFFF_FFFF, 4'hF);
    add_request(OP_LOOKUP, 32'hFFFF_FFFF, 32'h0000_0000, 4'h0);
    // Nested prefixes from /8 down to a host route with an all-ones mask.
    add_request(OP_INSERT, 32'h0A00_0000, 32'hFF00_0000, 4'h1);
    add_request(OP_INSERT, 32'h0A01_0000, 32'hFFFF_0000, 4'h2);
    add_request(OP_INSERT, 32'h0A01_0200, 32'hFFFF_FF00, 4'h3);
    add_request(OP_INSERT, 32'h0A01_0203, 32'hFFFF_FFFF, 4'hF);
    // Same prefix and mask again with another port: left unchanged.
    add_request(OP_INSERT, 32'h0A00_0000, 32'hFF00_0000, 4'h9);
    // Same prefix with a different mask is a new route.
    add_request(OP_INSERT, 32'h0A00_0000, 32'hFFFF_0000, 4'h4);
    // Scattered mask of sixteen ones; ties with the /16 routes above.
    add_request(OP_INSERT, 32'h0A00_0000, 32'hFF00_FF00, 4'h5);
    // Prefix bits outside the mask, and an empty mask with a nonzero prefix: never match.
    add_request(OP_INSERT, 32'hC0A8_0101, 32'hFFFF_0000, 4'h6);
    add_request(OP_INSERT, 32'h0000_0001, 32'h0000_0000, 4'h7);
    add_request(OP_LOOKUP, 32'h0A01_0203, 32'h1234_5678, 4'hA);
    add_request(OP_LOOKUP, 32'h0A01_0204, 32'h0, 4'h0);
    add_request(OP_LOOKUP, 32'h0A01_0301, 32'h0, 4'h0);
    add_request(OP_LOOKUP, 32'h0A01_0005, 32'h0, 4'h0);
    add_request(OP_LOOKUP, 32'h0A02_0000, 32'h0, 4'h0);
    add_request(OP_LOOKUP, 32'h0A00_0001, 32'h0, 4'h0);
    add_request(OP_LOOKUP, 32'h0AFF_FFFF, 32'h0, 4'h0);
    add_request(OP_LOOKUP, 32'hC0A8_0101, 32'h0, 4'h0);
    add_request(OP_LOOKUP, 32'hFFFF_FFFF, 32'h0, 4'h0);
    add_request(OP_LOOKUP, 32'h0000_0001, 32'h0, 4'h0);
    foreach (route_requests[i]) begin
      if (route_requests[i].opcode == OP_INSERT) begin
        issued_prefix = {issued_prefix, route_requests[i].address};
        issued_mask = {issued_mask, route_requests[i].prefix_mask};
      end
    end
    drain_marks = {route_requests.size(), route_requests.size() + 450,
                   route_requests.size() + 900};

    // Random part: mostly lookups aimed at routes already sent, so most of them hit and
    // compete on mask length; inserts first fill the table, then run into full or duplicate.
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      pick = $urandom_range(0, 99);
      kind = $urandom_range(0, 9);
      k = $urandom_range(0, issued_prefix.size() - 1);
      if (pick < 30) begin
        if (kind < 3) begin
          addr = issued_prefix[k];
          mask = issued_mask[k];
        end else if (kind < 8) begin
          mask = mask_of_length($urandom_range(0, 32));
          addr = $urandom() & mask;
        end else begin
          mask = $urandom();
          addr = $urandom();
        end
        issued_prefix = {issued_prefix, addr};
        issued_mask = {issued_mask, mask};
        add_request(OP_INSERT, addr, mask, 4'($urandom_range(0, 15)));
      end else begin
        addr = (issued_prefix[k] & issued_mask[k]) | ($urandom() & ~issued_mask[k]);
        if (kind >= 6 && kind < 8) begin
          addr ^= 32'h1 << $urandom_range(0, 31);
        end else if (kind == 8) begin
          addr = $urandom();
        end else if (kind == 9) begin
          addr = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0000_0000;
        end
        add_request(OP_LOOKUP, addr, $urandom(), 4'($urandom_range(0, 15)));
      end
    end

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    while (route_requests.size() != 0 || in_chan.valid || results_got != items_sent) begin
      @(posedge clk);
    end
    repeat (TABLE_DEPTH + 10) @(posedge clk);
    if (route_replies_due.size() != 0) begin
      fail_count++;
      $display("%0t: %0d results never arrived", $realtime, route_replies_due.size());
    end
    if (fail_count == 0) begin
      $display("longest_prefix_route_table_tb passed");
    end else begin
      $display("longest_prefix_route_table_tb failed");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("%0t: timeout", $realtime);
    $display("longest_prefix_route_table_tb failed");
    $finish;
  end

endmodule

FILE: files.f
sv/lprt_pkg.sv
sv/lprt_chan_if.sv
sv/lprt_cell.sv
sv/longest_prefix_route_table.sv
tb/longest_prefix_route_table_tb.sv
